// ===== rtl/bba_pkg.sv =====
// ============================================================================
// bba_pkg
// Shared types, constants and helpers for the bitmap block allocator.
// ============================================================================
package bba_pkg;

    localparam int NUM_BLOCKS = 1024;
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int WORD_W     = 64;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int MAP_WORDS  = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WORD_AW    = $clog2(MAP_WORDS);
    localparam int BYTES      = WORD_W / 8;
    localparam int BYTE_AW    = $clog2(BYTES);

    localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = CNT_W'(1024);
    localparam logic [CNT_W-1:0] NUM_BLOCKS_C    = CNT_W'(NUM_BLOCKS);

    typedef enum logic [1:0] {
        OP_MARK_USED = 2'd0,
        OP_MARK_FREE = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_QUERY     = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_SCAN,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic accept;
        logic rmw_rd;
        logic rmw_wr;
        logic scan_init;
        logic scan_run;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_status;

    // Position of the lowest set bit: pick the byte first, then the bit in it.
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [BYTE_AW-1:0] sel;
        logic [7:0]         byte_v;
        logic [2:0]         pos;
        sel = '0;
        pos = '0;
        for (int j = BYTES - 1; j >= 0; j--) begin
            if (|v[j*8 +: 8]) sel = BYTE_AW'(j);
        end
        byte_v = v[sel*8 +: 8];
        for (int k = 7; k >= 0; k--) begin
            if (byte_v[k]) pos = 3'(k);
        end
        return {sel, pos};
    endfunction

endpackage

// ===== rtl/bba_ctrl.sv =====
// ============================================================================
// bba_ctrl
// Sequencer: accept, read-modify-write of one map word, scan, result load.
// ============================================================================
module bba_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  bba_pkg::t_op    i_op,
    output logic            o_in_ready,
    input  bba_pkg::t_status i_status,
    output bba_pkg::t_cmd   o_cmd
);
    import bba_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   is_mark;

    assign is_mark = (i_op == OP_MARK_USED) || (i_op == OP_MARK_FREE);
    assign accept  = (r_state == ST_IDLE) && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = is_mark ? ST_RMW_RD : ST_SCAN;
            end
            ST_RMW_RD: n_state = ST_RMW_WR;
            ST_RMW_WR: n_state = ST_SCAN;
            ST_SCAN: begin
                if (i_status.scan_done) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = (r_state == ST_IDLE);
        o_cmd           = '0;
        o_cmd.accept    = accept;
        o_cmd.rmw_rd    = (r_state == ST_RMW_RD);
        o_cmd.rmw_wr    = (r_state == ST_RMW_WR);
        o_cmd.scan_init = (accept && !is_mark) || (r_state == ST_RMW_WR);
        o_cmd.scan_run  = (r_state == ST_SCAN);
        o_cmd.load_out  = (r_state == ST_LOAD) && i_status.out_free;
    end

endmodule

// ===== rtl/bba_datapath.sv =====
// ============================================================================
// bba_datapath
// Usage map memory, used-block counter, word scan and result registers.
// ============================================================================
module bba_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bba_pkg::t_cmd                 i_cmd,
    output bba_pkg::t_status              o_status,
    input  bba_pkg::t_op                  i_op,
    input  logic [bba_pkg::IDX_W-1:0]     i_block_index,
    input  logic                          i_cfg_we,
    input  logic [bba_pkg::CNT_W-1:0]     i_cfg_wdata,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bba_pkg::IDX_W-1:0]     o_free_index,
    output logic                          o_disk_full,
    output logic [bba_pkg::CNT_W-1:0]     o_used_count
);
    import bba_pkg::*;

    logic [WORD_W-1:0]  mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] r_wvld;

    logic [CNT_W-1:0]   r_block_count;
    logic [CNT_W-1:0]   r_bound;
    t_op                r_op;
    logic [IDX_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_used;
    logic [CNT_W-1:0]   n_used;

    logic [WORD_AW:0]   r_scan_addr;
    logic               r_chk_vld;
    logic [WORD_AW-1:0] r_chk_word;
    logic [WORD_W-1:0]  r_rd_data;
    logic               r_rd_vld;

    logic [IDX_W-1:0]   r_res_idx;
    logic               r_res_full;
    logic               r_out_vld;

    logic               scan_issue;
    logic               rd_en;
    logic [WORD_AW-1:0] rd_addr;
    logic [WORD_AW-1:0] rmw_word;
    logic [BIT_W-1:0]   rmw_bit;
    logic [WORD_W-1:0]  cur_word;
    logic               old_bit;
    logic               want;
    logic               in_range;
    logic               flip;
    logic               wr_en;
    logic [WORD_W-1:0]  wr_data;

    logic [CNT_W-1:0]   base;
    logic [CNT_W-1:0]   rem;
    logic [WORD_W-1:0]  mask;
    logic [WORD_W-1:0]  cand;
    logic               hit;
    logic               last;
    logic               scan_done;
    logic [BIT_W-1:0]   hit_pos;

    assign rmw_word   = r_idx[IDX_W-1:BIT_W];
    assign rmw_bit    = r_idx[BIT_W-1:0];
    assign scan_issue = i_cmd.scan_run && (r_scan_addr < (WORD_AW+1)'(MAP_WORDS));
    assign rd_en      = i_cmd.rmw_rd || scan_issue;
    assign rd_addr    = i_cmd.rmw_rd ? rmw_word : r_scan_addr[WORD_AW-1:0];
    assign cur_word   = r_rd_vld ? r_rd_data : '0;

    // Read-modify-write of one map word
    assign old_bit  = cur_word[rmw_bit];
    assign want     = (r_op == OP_MARK_USED);
    assign in_range = ({1'b0, r_idx} < NUM_BLOCKS_C);
    assign flip     = i_cmd.rmw_wr && in_range && (old_bit != want);
    assign wr_en    = flip;
    assign wr_data  = cur_word ^ (WORD_W'(1) << rmw_bit);

    always_comb begin
        n_used = r_used;
        if (flip) n_used = want ? r_used + CNT_W'(1) : r_used - CNT_W'(1);
    end

    // Scan check on the word just read
    assign base = CNT_W'({r_chk_word, {BIT_W{1'b0}}});
    assign rem  = r_bound - base;
    always_comb begin
        if (r_bound <= base) begin
            mask = '0;
        end else if (rem >= CNT_W'(WORD_W)) begin
            mask = '1;
        end else begin
            mask = ~({WORD_W{1'b1}} << rem[BIT_W-1:0]);
        end
    end
    assign cand      = ~cur_word & mask;
    assign hit       = |cand;
    assign hit_pos   = lowest_set(cand);
    assign last      = (r_bound <= base + CNT_W'(WORD_W))
                    || (r_chk_word == WORD_AW'(MAP_WORDS - 1));
    assign scan_done = i_cmd.scan_run && r_chk_vld && (hit || last);

    assign o_status.scan_done = scan_done;
    assign o_status.out_free  = !r_out_vld || i_out_ready;

    // Map memory
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[rmw_word] <= wr_data;
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
            r_rd_vld  <= r_wvld[rd_addr];
        end
    end

    // Per-word valid bits: a word not yet written reads as all free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvld <= '0;
        end else if (i_cmd.accept && (i_op == OP_CLEAR)) begin
            r_wvld <= '0;
        end else if (wr_en) begin
            r_wvld[rmw_word] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= BLOCK_COUNT_RST;
            r_used        <= '0;
            r_scan_addr   <= '0;
            r_chk_vld     <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) r_block_count <= i_cfg_wdata;
            if (i_cmd.accept && (i_op == OP_CLEAR)) begin
                r_used <= '0;
            end else begin
                r_used <= n_used;
            end
            if (i_cmd.scan_init) begin
                r_scan_addr <= '0;
                r_chk_vld   <= 1'b0;
            end else begin
                if (scan_issue) r_scan_addr <= r_scan_addr + (WORD_AW+1)'(1);
                r_chk_vld <= scan_issue;
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_op;
            r_idx   <= i_block_index;
            r_bound <= (r_block_count > NUM_BLOCKS_C) ? NUM_BLOCKS_C : r_block_count;
        end
        if (scan_issue) r_chk_word <= r_scan_addr[WORD_AW-1:0];
        if (scan_done) begin
            r_res_idx  <= hit ? {r_chk_word, hit_pos} : '0;
            r_res_full <= !hit;
        end
        if (i_cmd.load_out) begin
            o_free_index <= r_res_idx;
            o_disk_full  <= r_res_full;
            o_used_count <= r_used;
        end
    end

    assign o_out_valid = r_out_vld;

    a_full_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_disk_full |-> o_free_index == '0)
        else $error("full result carries nonzero free index");

    a_used_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= NUM_BLOCKS_C)
        else $error("used count exceeds map size");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept && (i_op == OP_CLEAR) |=> r_used == '0 && r_wvld == '0)
        else $error("clear did not empty the map");

    a_hit_in_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_done && hit |-> CNT_W'({r_chk_word, hit_pos}) < r_bound)
        else $error("free block found beyond bound");

endmodule

// ===== rtl/bitmap_block_allocator_top.sv =====
// ============================================================================
// bitmap_block_allocator_top
// One-bit-per-block usage map with lowest-free search and used-block count.
// ============================================================================
// Each transaction applies a mark-used, mark-free, clear-all or query op and
// returns the lowest free block below block_count, a full flag and the used
// count. The map lives in a 16 x 64-bit memory with one read port; the search
// reads one word per cycle and stops at the first word holding a free block
// or at the bound. A mark op reads and rewrites its map word before the scan;
// clear and query go straight to the scan, and at most 16 words are scanned.
// Clear-all resets the used count and the word valid bits on acceptance. A new
// transaction is taken while the previous result still waits on the output.
module bitmap_block_allocator_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_op,
    input  logic [bba_pkg::IDX_W-1:0] i_block_index,
    input  logic                      i_cfg_we,
    input  logic [bba_pkg::CNT_W-1:0] i_cfg_wdata,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [bba_pkg::IDX_W-1:0] o_free_index,
    output logic                      o_disk_full,
    output logic [bba_pkg::CNT_W-1:0] o_used_count
);
    import bba_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_op     op;

    assign op = t_op'(i_op);

    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (op),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bba_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_op          (op),
        .i_block_index (i_block_index),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_free_index  (o_free_index),
        .o_disk_full   (o_disk_full),
        .o_used_count  (o_used_count)
    );

endmodule
